// ----- rtl/core/qsort_pkg.sv -----
// ----------------------------------------------------------------------------
// qsort_pkg
// shared types and codes for the quicksort sorter
// ----------------------------------------------------------------------------
`default_nettype none
package qsort_pkg;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_RANGE   = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/core/qsort_ram.sv -----
// ----------------------------------------------------------------------------
// qsort_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module qsort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/quicksort_sorter.sv -----
// ----------------------------------------------------------------------------
// quicksort_sorter
// loads signed values, sorts them in place by lomuto quicksort, reads them back
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata low bit up)            tuser  tlast
// s_axis   in   value[31:0], index[41:32], pad       mode   last
// m_axis   out  data[31:0], status[33:32], pad       -      -
//
// a load answers from its accept; a read steps through accept, memory read, result
// a load with last then runs the sort on the single memory port, with states for
// reading and comparing, swapping, pivot read and final swap, and stack pop
// s_axis tready stays low while the sort or a read is in progress, and while
// a result waits in the output register and m_axis does not take it that cycle
// reset clears the count and control; the store holds no valid state
// ----------------------------------------------------------------------------
`default_nettype none
module quicksort_sorter #(
	parameter int CAPACITY = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [47:0] s_axis_tdata,   // value[31:0], index[41:32]
	input  wire         s_axis_tuser,   // mode
	input  wire         s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata    // data[31:0], status[33:32]
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SD = AW + 1;
	localparam int SPW = $clog2(SD + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2,
		S_POP = 4'd3, S_PIV = 4'd4, S_PIVW = 4'd5, S_JRD = 4'd6,
		S_JCMP = 4'd7, S_IRD = 4'd8, S_SWJ = 4'd9, S_SWI = 4'd10,
		S_FRD = 4'd11, S_FSW = 4'd12, S_FIN = 4'd13, S_SPLIT = 4'd14,
		S_CHK = 4'd15;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] lo_q, hi_q, j_q, i_q;
	logic          ivalid_q;          // i_q = lo - 1 when low
	logic [31:0]   pivot_q, vj_q;
	logic [AW-1:0] stk_lo_q [SD];
	logic [AW-1:0] stk_hi_q [SD];
	logic [SPW-1:0] sp_q;
	logic          mv_q;
	logic [31:0]   mdata_q;
	qsort_pkg::status_t mstat_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [31:0]   wdata, rdata;

	qsort_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	wire         in_mode = s_axis_tuser;
	wire [31:0]  in_val  = s_axis_tdata[31:0];
	wire [9:0]   in_idx  = s_axis_tdata[41:32];
	wire         out_free = !mv_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	wire         acc = s_axis_tvalid && s_axis_tready;
	wire         full = (count_q == CW'(CAPACITY));
	wire [AW-1:0] inext = ivalid_q ? i_q + AW'(1) : lo_q;
	wire         lt = $signed(rdata) < $signed(pivot_q);
	wire [AW-1:0] p = inext;
	wire [AW:0]  left_n = {1'b0, p} - {1'b0, lo_q};
	wire [AW:0]  right_n = {1'b0, hi_q} - {1'b0, p};
	wire         rd_ok = ({22'd0, in_idx} < 32'(count_q)) && (32'(in_idx) < CAPACITY);

	assign m_axis_tvalid = mv_q;
	assign m_axis_tdata = {6'd0, mstat_q, mdata_q};

	always_comb begin
		we = 1'b0; addr = '0; wdata = pivot_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && in_mode == qsort_pkg::MODE_LOAD && !full) begin
					we = 1'b1; addr = count_q[AW-1:0]; wdata = in_val;
				end else addr = AW'(in_idx);
			end
			S_PIV:  addr = hi_q;
			S_JRD:  addr = j_q;
			S_IRD:  addr = inext;
			S_SWJ:  begin we = 1'b1; addr = j_q; wdata = rdata; end
			S_SWI:  begin we = 1'b1; addr = i_q; wdata = vj_q; end
			S_FRD:  addr = inext;
			S_FSW:  begin we = 1'b1; addr = hi_q; wdata = rdata; end
			S_FIN:  begin we = 1'b1; addr = inext; wdata = pivot_q; end
			default: addr = j_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; count_q <= '0; sp_q <= '0; mv_q <= 1'b0;
			ivalid_q <= 1'b0;
		end else begin
			if (mv_q && m_axis_tready) mv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc) begin
					if (in_mode == qsort_pkg::MODE_READ) begin
						if (rd_ok) begin
							// read address held for the second memory read
							j_q <= AW'(in_idx);
							state_q <= S_RD;
						end else begin
							mv_q <= 1'b1; mdata_q <= '0; mstat_q <= qsort_pkg::ST_RANGE;
						end
					end else begin
						mv_q <= 1'b1; mdata_q <= '0;
						mstat_q <= full ? qsort_pkg::ST_FULL : qsort_pkg::ST_OK;
						if (!full) count_q <= count_q + CW'(1);
						if (s_axis_tlast) state_q <= S_CHK;
					end
				end
				S_RD:  state_q <= S_RDW;
				S_RDW: begin
					mv_q <= 1'b1; mdata_q <= rdata; mstat_q <= qsort_pkg::ST_OK;
					state_q <= S_IDLE;
				end
				S_CHK: begin
					if (count_q < CW'(2)) state_q <= S_IDLE;
					else begin
						lo_q <= '0; hi_q <= AW'(count_q - CW'(1));
						state_q <= S_SPLIT;
					end
				end
				S_POP: begin
					if (sp_q == '0) state_q <= S_IDLE;
					else begin
						lo_q <= stk_lo_q[sp_q - SPW'(1)];
						hi_q <= stk_hi_q[sp_q - SPW'(1)];
						sp_q <= sp_q - SPW'(1);
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					if (lo_q < hi_q) begin
						j_q <= lo_q; ivalid_q <= 1'b0; state_q <= S_PIV;
					end else state_q <= S_POP;
				end
				S_PIV:  state_q <= S_PIVW;
				S_PIVW: begin
					pivot_q <= rdata;
					state_q <= (j_q < hi_q) ? S_JRD : S_FRD;
				end
				S_JRD:  state_q <= S_JCMP;
				S_JCMP: begin
					vj_q <= rdata;
					if (lt) state_q <= S_IRD;
					else begin
						j_q <= j_q + AW'(1);
						state_q <= (j_q + AW'(1) < hi_q) ? S_JRD : S_FRD;
					end
				end
				S_IRD: begin
					i_q <= inext; ivalid_q <= 1'b1; state_q <= S_SWJ;
				end
				S_SWJ: state_q <= S_SWI;
				S_SWI: begin
					j_q <= j_q + AW'(1);
					state_q <= (j_q + AW'(1) < hi_q) ? S_JRD : S_FRD;
				end
				S_FRD: state_q <= S_FSW;
				S_FSW: state_q <= S_FIN;
				S_FIN: begin
					if (left_n > right_n) begin
						if (p - AW'(1) > lo_q) begin
							stk_lo_q[sp_q] <= lo_q; stk_hi_q[sp_q] <= p - AW'(1);
							sp_q <= sp_q + SPW'(1);
						end
						// pivot at the top end leaves an empty right part
						if (p == hi_q) hi_q <= lo_q;
						else lo_q <= p + AW'(1);
					end else begin
						if (p + AW'(1) < hi_q && p < hi_q) begin
							stk_lo_q[sp_q] <= p + AW'(1); stk_hi_q[sp_q] <= hi_q;
							sp_q <= sp_q + SPW'(1);
						end
						if (p == lo_q) lo_q <= hi_q;
						else hi_q <= p - AW'(1);
					end
					state_q <= S_SPLIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- tb/quicksort_sorter_test.sv -----
// ----------------------------------------------------------------------------
// quicksort_sorter_test
// streams loads and reads into the sorter and checks each result beat
// against an in-bench sort of the same store contents
// ----------------------------------------------------------------------------
`default_nettype none
module quicksort_sorter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 1024;
	localparam int STALL_LIMIT = 10000000;

	typedef struct packed {
		logic [31:0] data;
		qsort_pkg::status_t status;
	} sort_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	quicksort_sorter #(.CAPACITY(CAPACITY)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [31:0] shadow_store [CAPACITY];
	int                 shadow_count = 0;
	sort_result_t       pending_results [$];
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	bit                 calm = 1'b0;
	bit                 hold_sink = 1'b0;

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		$display("mismatch: %s got %h want %h", what, got, want);
		mismatches++;
	endtask

	// lomuto quicksort with explicit range stack, larger part pushed
	function automatic void sort_shadow();
		int lo_q [$];
		int hi_q [$];
		int lo, hi, i, p;
		logic signed [31:0] pv, t;
		if (shadow_count < 2) return;
		lo_q.push_back(0);
		hi_q.push_back(shadow_count - 1);
		while (lo_q.size() > 0) begin
			lo = lo_q.pop_back();
			hi = hi_q.pop_back();
			while (lo < hi) begin
				pv = shadow_store[hi];
				i = lo - 1;
				for (int j = lo; j < hi; j++) begin
					if (shadow_store[j] < pv) begin
						i++;
						t = shadow_store[i]; shadow_store[i] = shadow_store[j]; shadow_store[j] = t;
					end
				end
				p = i + 1;
				t = shadow_store[p]; shadow_store[p] = shadow_store[hi]; shadow_store[hi] = t;
				if (p - lo > hi - p) begin
					if (lo < p - 1) begin lo_q.push_back(lo); hi_q.push_back(p - 1); end
					lo = p + 1;
				end else begin
					if (p + 1 < hi) begin lo_q.push_back(p + 1); hi_q.push_back(hi); end
					hi = p - 1;
				end
			end
		end
	endfunction

	function automatic sort_result_t predict(input logic mode, input logic [31:0] value,
		input logic last, input logic [9:0] index);
		sort_result_t r;
		r = '{data: '0, status: qsort_pkg::ST_OK};
		if (mode == qsort_pkg::MODE_LOAD) begin
			if (shadow_count < CAPACITY) begin
				shadow_store[shadow_count] = value;
				shadow_count++;
			end else begin
				r.status = qsort_pkg::ST_FULL;
			end
			if (last) sort_shadow();
		end else if (index < shadow_count) begin
			r.data = shadow_store[index];
		end else begin
			r.status = qsort_pkg::ST_RANGE;
		end
		return r;
	endfunction

	task automatic send_beat(input logic mode, input logic [31:0] value,
		input logic last, input logic [9:0] index);
		while (!calm && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tlast <= last;
		s_axis_tdata <= {6'd0, index, value};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(predict(mode, value, last, index));
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(7) - 3;
			default: return $urandom;
		endcase
	endfunction

	// result checking
	always @(posedge clk) begin
		sort_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report("unexpected beat", m_axis_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== want.data)
					report("data", m_axis_tdata, {6'd0, want});
				if (m_axis_tdata[33:32] !== want.status)
					report("status", m_axis_tdata, {6'd0, want});
			end
		end
	end

	always @(posedge clk) begin
		if (hold_sink) m_axis_tready <= 1'b0;
		else if (calm) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_directed();
		send_beat(qsort_pkg::MODE_READ, 32'd0, 1'b0, 10'd0);      // read with empty store
		send_beat(qsort_pkg::MODE_LOAD, 32'h7fff_ffff, 1'b1, 10'd0); // single element sort
		send_beat(qsort_pkg::MODE_READ, 32'd0, 1'b1, 10'd0);      // last on a read is ignored
		send_beat(qsort_pkg::MODE_LOAD, 32'h8000_0000, 1'b0, 10'h3ff);
		send_beat(qsort_pkg::MODE_LOAD, 32'd5, 1'b0, 10'd0);
		send_beat(qsort_pkg::MODE_READ, 32'hffff_ffff, 1'b0, 10'd2); // read before sort
		send_beat(qsort_pkg::MODE_LOAD, 32'hffff_ffff, 1'b0, 10'd0);
		send_beat(qsort_pkg::MODE_LOAD, 32'd5, 1'b1, 10'd0);      // duplicates
		for (int k = 0; k < 6; k++) send_beat(qsort_pkg::MODE_READ, $urandom, 1'b0, 10'(k));
		send_beat(qsort_pkg::MODE_READ, 32'd0, 1'b0, 10'h3ff);
		end_burst();
	endtask

	task automatic test_random_sets();
		int n;
		for (int set = 0; set < 45; set++) begin
			n = $urandom_range(1, 20);
			for (int k = 0; k < n; k++)
				send_beat(qsort_pkg::MODE_LOAD, rand_value(), k == n - 1, 10'($urandom));
			n = $urandom_range(6, 26);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(9) == 0)
					send_beat(qsort_pkg::MODE_LOAD, rand_value(), 1'b0, 10'($urandom));
				else if ($urandom_range(9) == 0)
					send_beat(qsort_pkg::MODE_READ, $urandom, 1'($urandom), 10'($urandom));
				else
					send_beat(qsort_pkg::MODE_READ, $urandom, 1'($urandom),
						10'($urandom_range(shadow_count)));
			end
		end
		end_burst();
	endtask

	// fill to capacity with no idling, then overflow and read back
	task automatic test_full_store();
		calm = 1'b1;
		while (shadow_count < CAPACITY)
			send_beat(qsort_pkg::MODE_LOAD, rand_value(), 1'b0, 10'($urandom));
		calm = 1'b0;
		send_beat(qsort_pkg::MODE_LOAD, rand_value(), 1'b0, 10'd0);
		send_beat(qsort_pkg::MODE_LOAD, rand_value(), 1'b1, 10'd0); // dropped, sort still runs
		for (int k = 0; k < 40; k++)
			send_beat(qsort_pkg::MODE_READ, $urandom, 1'($urandom), 10'($urandom));
		send_beat(qsort_pkg::MODE_READ, 32'd0, 1'b0, 10'd0);
		send_beat(qsort_pkg::MODE_READ, 32'd0, 1'b0, 10'h3ff);
		end_burst();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_sink = 1'b1;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
			for (int k = 0; k < 30; k++)
				send_beat(qsort_pkg::MODE_READ, $urandom, 1'b0, 10'($urandom));
		join
		end_burst();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_sets();
		test_full_store();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/qsort_pkg.sv
rtl/core/qsort_ram.sv
rtl/core/quicksort_sorter.sv
tb/quicksort_sorter_test.sv
